// File: hw/rtl/dda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 24;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_BITS   = FRAC_BITS + 2;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(QUO_BITS + 1);

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic                  is_start;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] mag_x;
        logic [COORD_BITS-1:0] mag_y;
        logic                  neg_x;
        logic                  neg_y;
        logic [COORD_BITS-1:0] length;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_DIV
    } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dda_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_front (
    input  wire  dda_pkg::in_item_t     cmd_data,
    input  wire                         cmd_valid,
    output logic                        cmd_ready,
    input  wire  dda_pkg::fifo_status_t status,
    output logic                        push,
    output dda_pkg::q_entry_t           entry
);

    logic                           swap;
    logic [dda_pkg::COORD_BITS-1:0] x0;
    logic [dda_pkg::COORD_BITS-1:0] y0;
    logic [dda_pkg::COORD_BITS-1:0] x1;
    logic [dda_pkg::COORD_BITS-1:0] y1;
    logic [dda_pkg::COORD_BITS-1:0] mag_x;
    logic [dda_pkg::COORD_BITS-1:0] mag_y;

    assign cmd_ready = !status.full;
    assign push      = cmd_valid && !status.full;

    always_comb
    begin
        if (cmd_data.start_x == cmd_data.end_x)
        begin
            swap = cmd_data.start_y > cmd_data.end_y;
        end
        else
        begin
            swap = cmd_data.start_x > cmd_data.end_x;
        end
        x0 = swap ? cmd_data.end_x : cmd_data.start_x;
        y0 = swap ? cmd_data.end_y : cmd_data.start_y;
        x1 = swap ? cmd_data.start_x : cmd_data.end_x;
        y1 = swap ? cmd_data.start_y : cmd_data.end_y;
        mag_x = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
        mag_y = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
        entry.is_start = (cmd_data.cmd == dda_pkg::CMD_START);
        entry.x0       = x0;
        entry.y0       = y0;
        entry.mag_x    = mag_x;
        entry.mag_y    = mag_y;
        entry.neg_x    = x1 < x0;
        entry.neg_y    = y1 < y0;
        entry.length   = (mag_x > mag_y) ? mag_x : mag_y;
    end

endmodule

`default_nettype wire

// File: hw/rtl/dda_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_fifo (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         push,
    input  wire  dda_pkg::q_entry_t     wr_entry,
    input  wire                         pop,
    output dda_pkg::q_entry_t           rd_entry,
    output dda_pkg::fifo_status_t       status
);

    dda_pkg::q_entry_t mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign rd_entry     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dda_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire  dda_pkg::q_entry_t     entry,
    input  wire  dda_pkg::fifo_status_t status,
    output logic                        pop,
    output logic                        pix_valid,
    input  wire                         pix_ready,
    output dda_pkg::out_item_t          pix_data
);

    localparam int C = dda_pkg::COORD_BITS;
    localparam int F = dda_pkg::FRAC_BITS;
    localparam int A = dda_pkg::ACC_BITS;
    localparam int I = dda_pkg::INC_BITS;
    localparam int Q = dda_pkg::QUO_BITS;
    localparam int N = dda_pkg::CNT_BITS;

    dda_pkg::back_state_t state_reg, state_next;
    logic                 busy_reg, busy_next;
    logic                 out_valid_reg, out_valid_next;
    logic [N-1:0]         cnt_reg, cnt_next;

    logic signed [A-1:0]  acc_x_reg, acc_x_next;
    logic signed [A-1:0]  acc_y_reg, acc_y_next;
    logic signed [I-1:0]  inc_x_reg, inc_x_next;
    logic signed [I-1:0]  inc_y_reg, inc_y_next;
    logic [C-1:0]         left_reg, left_next;
    logic [C-1:0]         len_reg, len_next;
    logic [C-1:0]         rx_reg, rx_next;
    logic [C-1:0]         ry_reg, ry_next;
    logic [Q-1:0]         qx_reg, qx_next;
    logic [Q-1:0]         qy_reg, qy_next;
    logic                 negx_reg, negx_next;
    logic                 negy_reg, negy_next;
    dda_pkg::out_item_t   out_data_reg, out_data_next;

    logic                 out_free;
    logic                 first_step;
    logic [C:0]           tx;
    logic [C:0]           ty;
    logic signed [A-1:0]  sum_x;
    logic signed [A-1:0]  sum_y;

    function automatic logic [C-1:0] round_coord(input logic signed [A-1:0] acc);
        logic signed [A-1:0] v;
        begin
            v = acc + (A'(1) <<< (F - 1));
            round_coord = v[A-1] ? '0 : v[F+C-1:F];
        end
    endfunction

    function automatic logic signed [I-1:0] signed_step(input logic [Q-1:0] q,
                                                        input logic neg);
        logic signed [I-1:0] mag;
        begin
            mag = {1'b0, q};
            signed_step = neg ? -mag : mag;
        end
    endfunction

    assign pix_valid = out_valid_reg;
    assign pix_data  = out_data_reg;
    assign out_free  = !out_valid_reg || pix_ready;

    assign first_step = (cnt_reg == N'(Q));
    assign tx    = first_step ? {1'b0, rx_reg} : {rx_reg, 1'b0};
    assign ty    = first_step ? {1'b0, ry_reg} : {ry_reg, 1'b0};
    assign sum_x = acc_x_reg + {{(A - I){inc_x_reg[I-1]}}, inc_x_reg};
    assign sum_y = acc_y_reg + {{(A - I){inc_y_reg[I-1]}}, inc_y_reg};

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        inc_x_next     = inc_x_reg;
        inc_y_next     = inc_y_reg;
        left_next      = left_reg;
        len_next       = len_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        negx_next      = negx_reg;
        negy_next      = negy_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !pix_ready;
        pop            = 1'b0;

        case (state_reg)
            dda_pkg::BACK_IDLE:
            begin
                if (!status.empty)
                begin
                    if (entry.is_start)
                    begin
                        if (entry.length != '0)
                        begin
                            pop        = 1'b1;
                            busy_next  = 1'b0;
                            acc_x_next = A'({entry.x0, F'(0)});
                            acc_y_next = A'({entry.y0, F'(0)});
                            left_next  = entry.length;
                            len_next   = entry.length;
                            rx_next    = entry.mag_x;
                            ry_next    = entry.mag_y;
                            negx_next  = entry.neg_x;
                            negy_next  = entry.neg_y;
                            qx_next    = '0;
                            qy_next    = '0;
                            cnt_next   = N'(Q);
                            state_next = dda_pkg::BACK_DIV;
                        end
                        else if (out_free)
                        begin
                            pop            = 1'b1;
                            busy_next      = 1'b0;
                            acc_x_next     = A'({entry.x0, F'(0)});
                            acc_y_next     = A'({entry.y0, F'(0)});
                            inc_x_next     = '0;
                            inc_y_next     = '0;
                            left_next      = '0;
                            out_valid_next = 1'b1;
                            out_data_next.pixel_x = entry.x0;
                            out_data_next.pixel_y = entry.y0;
                            out_data_next.last    = 1'b1;
                        end
                    end
                    else if (!busy_reg)
                    begin
                        pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        pop            = 1'b1;
                        acc_x_next     = sum_x;
                        acc_y_next     = sum_y;
                        left_next      = left_reg - C'(1);
                        busy_next      = (left_reg != C'(1));
                        out_valid_next = 1'b1;
                        out_data_next.pixel_x = round_coord(sum_x);
                        out_data_next.pixel_y = round_coord(sum_y);
                        out_data_next.last    = (left_reg == C'(1));
                    end
                end
            end
            dda_pkg::BACK_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - N'(1);
                    if (tx >= {1'b0, len_reg})
                    begin
                        rx_next = C'(tx - {1'b0, len_reg});
                        qx_next = {qx_reg[Q-2:0], 1'b1};
                    end
                    else
                    begin
                        rx_next = tx[C-1:0];
                        qx_next = {qx_reg[Q-2:0], 1'b0};
                    end
                    if (ty >= {1'b0, len_reg})
                    begin
                        ry_next = C'(ty - {1'b0, len_reg});
                        qy_next = {qy_reg[Q-2:0], 1'b1};
                    end
                    else
                    begin
                        ry_next = ty[C-1:0];
                        qy_next = {qy_reg[Q-2:0], 1'b0};
                    end
                end
                else if (out_free)
                begin
                    inc_x_next     = signed_step(qx_reg, negx_reg);
                    inc_y_next     = signed_step(qy_reg, negy_reg);
                    busy_next      = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next.pixel_x = round_coord(acc_x_reg);
                    out_data_next.pixel_y = round_coord(acc_y_reg);
                    out_data_next.last    = 1'b0;
                    state_next     = dda_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = dda_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dda_pkg::BACK_IDLE;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            inc_x_reg     <= '0;
            inc_y_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            inc_x_reg     <= inc_x_next;
            inc_y_reg     <= inc_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        negx_reg     <= negx_next;
        negy_reg     <= negy_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/dda_line_rasterizer_top.sv
// Advance transactions pass through the queue and the output register and sustain one point per
// cycle while the receiver keeps pix_ready high. A start transaction with a nonzero length waits
// on a radix-2 divider that computes both steps before its first point appears.
// A zero-length start emits its single point, marked last, without entering the divider.
// Reset is asynchronous and active low; it empties the queue and leaves no line in progress.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer_top (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cmd_valid,
    output logic                    cmd_ready,
    input  wire  dda_pkg::in_item_t cmd_data,
    output logic                    pix_valid,
    input  wire                     pix_ready,
    output dda_pkg::out_item_t      pix_data
);

    dda_pkg::q_entry_t     wr_entry;
    dda_pkg::q_entry_t     rd_entry;
    dda_pkg::fifo_status_t status;
    logic                  push;
    logic                  pop;

    dda_front u_front (
        .cmd_data  (cmd_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .status    (status),
        .push      (push),
        .entry     (wr_entry)
    );

    dda_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .status   (status)
    );

    dda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .entry     (rd_entry),
        .status    (status),
        .pop       (pop),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 200;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 60;
    localparam int COORD_MAX    = (1 << dda_pkg::COORD_BITS) - 1;

    typedef logic signed [dda_pkg::ACC_BITS-1:0] acc_t;
    typedef logic signed [dda_pkg::INC_BITS-1:0] inc_t;

    class line_tracker;
        acc_t                         acc_x;
        acc_t                         acc_y;
        inc_t                         inc_x;
        inc_t                         inc_y;
        logic [dda_pkg::COORD_BITS:0] points_left;
        bit                           busy;
        dda_pkg::out_item_t           expected_pixels[$];
        int unsigned                  errors;

        function new();
            acc_x       = '0;
            acc_y       = '0;
            inc_x       = '0;
            inc_y       = '0;
            points_left = '0;
            busy        = 1'b0;
            errors      = 0;
        endfunction

        function logic [dda_pkg::COORD_BITS-1:0] nearest_coord(acc_t acc);
            longint v;
            v = longint'(acc) + (longint'(1) << (dda_pkg::FRAC_BITS - 1));
            if (v < 0)
                return '0;
            v = v >> dda_pkg::FRAC_BITS;
            return v[dda_pkg::COORD_BITS-1:0];
        endfunction

        function inc_t step_size(int delta, int length);
            longint mag;
            longint q;
            mag = (delta < 0) ? -longint'(delta) : longint'(delta);
            q = (mag << dda_pkg::FRAC_BITS) / length;
            if (delta < 0)
                q = -q;
            return q[dda_pkg::INC_BITS-1:0];
        endfunction

        function void push_pixel(bit fin);
            dda_pkg::out_item_t p;
            p.pixel_x = nearest_coord(acc_x);
            p.pixel_y = nearest_coord(acc_y);
            p.last    = fin;
            expected_pixels.push_back(p);
        endfunction

        function bit note_command(dda_pkg::in_item_t item);
            int     x0;
            int     y0;
            int     x1;
            int     y1;
            int     t;
            int     dx;
            int     dy;
            int     len;
            longint a;
            if (item.cmd == dda_pkg::CMD_START)
            begin
                x0 = int'(item.start_x);
                y0 = int'(item.start_y);
                x1 = int'(item.end_x);
                y1 = int'(item.end_y);
                if ((x0 == x1) ? (y0 > y1) : (x0 > x1))
                begin
                    t  = x0;
                    x0 = x1;
                    x1 = t;
                    t  = y0;
                    y0 = y1;
                    y1 = t;
                end
                dx  = x1 - x0;
                dy  = y1 - y0;
                len = (dx < 0) ? -dx : dx;
                t   = (dy < 0) ? -dy : dy;
                if (t > len)
                    len = t;
                a     = longint'(x0) << dda_pkg::FRAC_BITS;
                acc_x = a[dda_pkg::ACC_BITS-1:0];
                a     = longint'(y0) << dda_pkg::FRAC_BITS;
                acc_y = a[dda_pkg::ACC_BITS-1:0];
                if (len == 0)
                begin
                    inc_x = '0;
                    inc_y = '0;
                end
                else
                begin
                    inc_x = step_size(dx, len);
                    inc_y = step_size(dy, len);
                end
                points_left = len[dda_pkg::COORD_BITS:0];
                busy        = (len != 0);
                push_pixel(len == 0);
                return 1'b1;
            end
            if (!busy)
                return 1'b0;
            a           = longint'(acc_x) + longint'(inc_x);
            acc_x       = a[dda_pkg::ACC_BITS-1:0];
            a           = longint'(acc_y) + longint'(inc_y);
            acc_y       = a[dda_pkg::ACC_BITS-1:0];
            points_left = points_left - 1'b1;
            busy        = (points_left != 0);
            push_pixel(points_left == 0);
            return 1'b1;
        endfunction

        function void mismatch(string field, logic [dda_pkg::COORD_BITS-1:0] want,
                               logic [dda_pkg::COORD_BITS-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        function void check_pixel(dda_pkg::out_item_t got);
            dda_pkg::out_item_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual (%0d, %0d, %0d)",
                         $time, got.pixel_x, got.pixel_y, got.last);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x)
                mismatch("pixel_x", want.pixel_x, got.pixel_x);
            if (got.pixel_y !== want.pixel_y)
                mismatch("pixel_y", want.pixel_y, got.pixel_y);
            if (got.last !== want.last)
                mismatch("last", {{(dda_pkg::COORD_BITS-1){1'b0}}, want.last},
                         {{(dda_pkg::COORD_BITS-1){1'b0}}, got.last});
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_ready;
    dda_pkg::in_item_t  cmd_data;
    logic               pix_valid;
    logic               pix_ready;
    dda_pkg::out_item_t pix_data;

    line_tracker tracker;
    int          items_done;
    int          pixels_seen;
    int          idle_cycles;
    bit          sender_eager;
    bit          hold_done;

    dda_line_rasterizer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_command(input dda_pkg::in_item_t item);
        int gap;
        gap = sender_eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_data  = item;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        if (tracker.note_command(item))
            items_done++;
        @(negedge clk);
    endtask

    task automatic start_line(input int x0, input int y0, input int x1, input int y1);
        dda_pkg::in_item_t item;
        item.cmd     = dda_pkg::CMD_START;
        item.start_x = x0[dda_pkg::COORD_BITS-1:0];
        item.start_y = y0[dda_pkg::COORD_BITS-1:0];
        item.end_x   = x1[dda_pkg::COORD_BITS-1:0];
        item.end_y   = y1[dda_pkg::COORD_BITS-1:0];
        send_command(item);
    endtask

    task automatic advance_line(input int n);
        dda_pkg::in_item_t item;
        int                coord;
        repeat (n)
        begin
            item.cmd     = dda_pkg::CMD_ADVANCE;
            coord        = $urandom_range(0, COORD_MAX);
            item.start_x = coord[dda_pkg::COORD_BITS-1:0];
            coord        = $urandom_range(0, COORD_MAX);
            item.start_y = coord[dda_pkg::COORD_BITS-1:0];
            coord        = $urandom_range(0, COORD_MAX);
            item.end_x   = coord[dda_pkg::COORD_BITS-1:0];
            coord        = $urandom_range(0, COORD_MAX);
            item.end_y   = coord[dda_pkg::COORD_BITS-1:0];
            send_command(item);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pix_valid && pix_ready)
        begin
            tracker.check_pixel(pix_data);
            pixels_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (pix_valid && pix_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // The receiver stalls once for a long stretch so that the block backs up into its input.
    initial
    begin
        int run;
        int gap;
        pix_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!hold_done && pixels_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                pix_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            pix_ready = 1'b1;
            repeat (run) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                pix_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        int r;
        int len;
        int x0;
        int y0;
        int x1;
        int y1;
        int dx;
        int dy;
        int t;
        tracker      = new();
        items_done   = 0;
        pixels_seen  = 0;
        idle_cycles  = 0;
        sender_eager = 1'b0;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd_data     = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        advance_line(1);
        start_line(0, 0, 0, 0);
        start_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        start_line(0, 0, 3, 0);
        advance_line(3);
        start_line(10, 3, 7, 5);
        advance_line(3);
        start_line(7, 20, 7, 17);
        advance_line(3);
        advance_line(1);
        start_line(0, 0, 2, 1);
        advance_line(2);
        start_line(0, 0, COORD_MAX, COORD_MAX);
        advance_line(2);
        start_line(COORD_MAX, 0, 0, COORD_MAX);
        advance_line(1);
        start_line(2048, 2048, 2048, 2048);

        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            sender_eager = ($urandom_range(0, 2) == 0);
            if (r < 72 || r >= 97)
            begin
                if (r >= 97)
                    len = $urandom_range(100, 400);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(13, 64);
                else
                    len = $urandom_range(0, 12);
                x0 = $urandom_range(0, COORD_MAX);
                y0 = $urandom_range(0, COORD_MAX);
                t  = $urandom_range(0, 2 * len);
                if ($urandom_range(0, 1) == 1)
                begin
                    dx = $urandom_range(0, 1) ? len : -len;
                    dy = t - len;
                end
                else
                begin
                    dy = $urandom_range(0, 1) ? len : -len;
                    dx = t - len;
                end
                x1 = x0 + dx;
                if (x1 < 0 || x1 > COORD_MAX)
                    x1 = x0 - dx;
                y1 = y0 + dy;
                if (y1 < 0 || y1 > COORD_MAX)
                    y1 = y0 - dy;
                start_line(x0, y0, x1, y1);
                if (r < 72 && $urandom_range(0, 6) == 0)
                    advance_line($urandom_range(0, len));
                else
                    advance_line(len);
                if ($urandom_range(0, 9) == 0)
                    advance_line($urandom_range(1, 2));
            end
            else if (r < 87)
            begin
                start_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                advance_line($urandom_range(0, 5));
            end
            else
            begin
                advance_line($urandom_range(1, 2));
            end
        end
        cmd_valid = 1'b0;

        while (tracker.expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_front.sv
hw/rtl/dda_fifo.sv
hw/rtl/dda_back.sv
hw/rtl/dda_line_rasterizer_top.sv
dv/tb.sv
